>>> hw/rtl/bde_pkg.sv
// shared types and codes for the bounded deque engine
`default_nettype none

package bde_pkg;

    // field widths fixed by the interface
    localparam int ModeW  = 4;
    localparam int ValueW = 32;
    localparam int CntW   = 7;
    localparam int KindW  = 3;

    // operation codes
    localparam logic [ModeW-1:0] MODE_PUSH_FRONT = 4'd0;
    localparam logic [ModeW-1:0] MODE_PUSH_BACK  = 4'd1;
    localparam logic [ModeW-1:0] MODE_POP_FRONT  = 4'd2;
    localparam logic [ModeW-1:0] MODE_POP_BACK   = 4'd3;
    localparam logic [ModeW-1:0] MODE_CLEAR      = 4'd4;
    localparam logic [ModeW-1:0] MODE_DELETE     = 4'd5;
    localparam logic [ModeW-1:0] MODE_READ_ALL   = 4'd6;
    localparam logic [ModeW-1:0] MODE_FIRST_N    = 4'd7;
    localparam logic [ModeW-1:0] MODE_LAST_N     = 4'd8;

    // result kinds
    localparam logic [KindW-1:0] KIND_ELEM  = 3'd0;
    localparam logic [KindW-1:0] KIND_EMPTY = 3'd1;
    localparam logic [KindW-1:0] KIND_DONE  = 3'd2;
    localparam logic [KindW-1:0] KIND_FULL  = 3'd3;
    localparam logic [KindW-1:0] KIND_NONE  = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DEL
    } t_state;

    // what every cell does with its neighbors this cycle
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_LEFT,
        SH_RIGHT
    } t_shift;

    typedef struct packed {
        t_shift op;
        logic   wr_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/bde_cell.sv
// one storage cell of the deque ring
`default_nettype none

module bde_cell
    import bde_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int IDX_W      = 6,
    parameter int IDX        = 0
) (
    input  wire                   i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire [IDX_W-1:0]       i_wr_idx,
    input  wire [WORD_WIDTH-1:0]  i_wr_data,
    input  wire [WORD_WIDTH-1:0]  i_from_left,
    input  wire [WORD_WIDTH-1:0]  i_from_right,
    output logic [WORD_WIDTH-1:0] o_word
);

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            SH_LEFT:  n_word = i_from_right;
            SH_RIGHT: n_word = i_from_left;
            default:  n_word = r_word;
        endcase
        // a direct write wins over the shift
        if (i_ctl.wr_en && (i_wr_idx == IDX_W'(IDX))) begin
            n_word = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

>>> hw/rtl/bounded_deque_engine_top.sv
// top level of the bounded deque engine: cell ring, sequencer and result register
// push, pop and clear: one transaction per cycle while the output register is free, status result registered
// delete value: one ring shift per entry, then the status; no new request is taken until it is out
// reads: the ring rotates once and elements come from one tap
// results stall the sequencer only while the output register is held by the consumer
// synchronous active-low reset empties the deque; stored words stay undefined until written
`default_nettype none

module bounded_deque_engine_top
    import bde_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // request channel
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire [ModeW-1:0]    i_mode,
    input  wire [ValueW-1:0]   i_value,
    input  wire [CntW-1:0]     i_count,
    // result channel
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic [ValueW-1:0]  o_out_value,
    output logic [KindW-1:0]   o_kind,
    output logic [CntW-1:0]    o_removed,
    output logic               o_last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // cell ring: cell 0 holds the front element whenever the sequencer is idle
    logic [WORD_WIDTH-1:0] w_cell [DEPTH];
    t_cell_ctl             w_ctl;
    logic [IW-1:0]         w_wr_idx;
    logic [WORD_WIDTH-1:0] w_wr_data;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            bde_cell #(
                .WORD_WIDTH (WORD_WIDTH),
                .IDX_W      (IW),
                .IDX        (gi)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_wr_idx     (w_wr_idx),
                .i_wr_data    (w_wr_data),
                .i_from_left  (w_cell[(gi + DEPTH - 1) % DEPTH]),
                .i_from_right (w_cell[(gi + 1) % DEPTH]),
                .o_word       (w_cell[gi])
            );
        end
    endgenerate

    // control state
    t_state                r_state, n_state;
    logic [CW-1:0]         r_occ, n_occ;
    logic [CW-1:0]         r_step, n_step;     // ring steps done in the current walk
    logic [CW-1:0]         r_n, n_n;           // elements to give in a read
    logic [CW-1:0]         r_kept, n_kept;     // entries kept by delete
    logic [IW-1:0]         r_wptr, n_wptr;     // where delete puts the next kept entry
    logic [IW-1:0]         r_tap, n_tap;       // read tap in the ring
    logic                  r_back, n_back;     // last-n walks toward the front
    logic [WORD_WIDTH-1:0] r_val, n_val;       // delete key

    // result register
    logic                  r_out_valid, n_out_valid;
    logic [ValueW-1:0]     r_out_value, n_out_value;
    logic [KindW-1:0]      r_out_kind, n_out_kind;
    logic [CntW-1:0]       r_out_removed, n_out_removed;
    logic                  r_out_last, n_out_last;

    logic                  w_can_load;
    logic                  w_in_acc;
    logic [WORD_WIDTH-1:0] w_in_word;
    logic [63:0]           w_in_ext;
    logic [CW-1:0]         w_occ_m1;
    logic                  w_full;
    logic                  w_empty;
    logic [CW-1:0]         w_rd_n;
    logic [WORD_WIDTH-1:0] w_tap_word;
    logic [ValueW-1:0]     w_tap_value;
    logic [WORD_WIDTH-1:0] w_head;
    logic                  w_keep;
    logic                  w_read_last_rot;
    logic                  w_read_emit;
    logic                  w_del_done;
    logic [CW-1:0]         w_removed;

    // output slot is free when empty or being taken this cycle
    assign w_can_load = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_can_load;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // input word sign-extended and then cut to the stored width
    assign w_in_ext  = {{32{i_value[ValueW-1]}}, i_value};
    assign w_in_word = w_in_ext[WORD_WIDTH-1:0];

    assign w_occ_m1 = r_occ - CW'(1);
    assign w_full   = (r_occ == CW'(DEPTH));
    assign w_empty  = (r_occ == '0);

    // read length: count cut to the held elements
    always_comb begin
        w_rd_n = r_occ;
        if (i_mode == MODE_FIRST_N || i_mode == MODE_LAST_N) begin
            if (i_count < CntW'(r_occ)) begin
                w_rd_n = CW'(i_count);
            end
        end
    end

    // stored word sign-extended and given in 32 bits
    assign w_tap_word = w_cell[r_tap];
    always_comb begin
        logic [WORD_WIDTH+63:0] ext;
        ext         = {{64{w_tap_word[WORD_WIDTH-1]}}, w_tap_word};
        w_tap_value = ext[ValueW-1:0];
    end

    assign w_head          = w_cell[0];
    assign w_keep          = (w_head != r_val);
    assign w_read_last_rot = (r_step == CW'(DEPTH - 1));
    assign w_read_emit     = (r_step < r_n);
    assign w_del_done      = (r_step == r_occ);
    assign w_removed       = r_occ - r_kept;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_mode == MODE_DELETE) begin
                        n_state = S_DEL;
                    end else if ((i_mode == MODE_READ_ALL || i_mode == MODE_FIRST_N ||
                                  i_mode == MODE_LAST_N) && (w_rd_n != '0)) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if ((w_can_load || !w_read_emit) && w_read_last_rot) begin
                    n_state = S_IDLE;
                end
            end
            S_DEL: begin
                if (w_del_done && w_can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_occ         = r_occ;
        n_step        = r_step;
        n_n           = r_n;
        n_kept        = r_kept;
        n_wptr        = r_wptr;
        n_tap         = r_tap;
        n_back        = r_back;
        n_val         = r_val;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_value   = r_out_value;
        n_out_kind    = r_out_kind;
        n_out_removed = r_out_removed;
        n_out_last    = r_out_last;
        w_ctl.op      = SH_HOLD;
        w_ctl.wr_en   = 1'b0;
        w_wr_idx      = '0;
        w_wr_data     = w_in_word;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    // status by default; reads and delete override below
                    n_out_value   = '0;
                    n_out_removed = '0;
                    n_out_last    = 1'b1;
                    n_out_kind    = KIND_DONE;
                    n_out_valid   = 1'b1;
                    case (i_mode)
                        MODE_PUSH_FRONT: begin
                            if (w_full) begin
                                n_out_kind = KIND_FULL;
                            end else begin
                                w_ctl.op    = SH_RIGHT;
                                w_ctl.wr_en = 1'b1;
                                w_wr_idx    = '0;
                                n_occ       = r_occ + CW'(1);
                            end
                        end
                        MODE_PUSH_BACK: begin
                            if (w_full) begin
                                n_out_kind = KIND_FULL;
                            end else begin
                                w_ctl.wr_en = 1'b1;
                                w_wr_idx    = r_occ[IW-1:0];
                                n_occ       = r_occ + CW'(1);
                            end
                        end
                        MODE_POP_FRONT: begin
                            if (w_empty) begin
                                n_out_kind = KIND_NONE;
                            end else begin
                                w_ctl.op = SH_LEFT;
                                n_occ    = w_occ_m1;
                            end
                        end
                        MODE_POP_BACK: begin
                            if (w_empty) begin
                                n_out_kind = KIND_NONE;
                            end else begin
                                n_occ = w_occ_m1;
                            end
                        end
                        MODE_CLEAR: begin
                            n_occ = '0;
                        end
                        MODE_DELETE: begin
                            n_out_valid = 1'b0;
                            n_step      = '0;
                            n_kept      = '0;
                            n_wptr      = w_occ_m1[IW-1:0];
                            n_val       = w_in_word;
                        end
                        MODE_READ_ALL, MODE_FIRST_N, MODE_LAST_N: begin
                            if (w_rd_n == '0) begin
                                n_out_kind = KIND_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_step      = '0;
                                n_n         = w_rd_n;
                                n_back      = (i_mode == MODE_LAST_N);
                                n_tap       = (i_mode == MODE_LAST_N) ? w_occ_m1[IW-1:0] : '0;
                            end
                        end
                        default: begin
                            // unused codes take the transaction and give nothing
                            n_out_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_READ: begin
                // one ring rotation per step, DEPTH steps bring the ring home
                if (w_can_load || !w_read_emit) begin
                    w_ctl.op = r_back ? SH_RIGHT : SH_LEFT;
                    n_step   = r_step + CW'(1);
                    if (w_read_emit) begin
                        n_out_valid   = 1'b1;
                        n_out_value   = w_tap_value;
                        n_out_kind    = KIND_ELEM;
                        n_out_removed = '0;
                        n_out_last    = (r_step == r_n - CW'(1));
                    end
                end
            end
            S_DEL: begin
                if (!w_del_done) begin
                    // pull the front entry out and append it behind the kept run
                    w_ctl.op    = SH_LEFT;
                    w_ctl.wr_en = w_keep;
                    w_wr_idx    = r_wptr;
                    w_wr_data   = w_head;
                    n_step      = r_step + CW'(1);
                    if (w_keep) begin
                        n_kept = r_kept + CW'(1);
                    end else begin
                        n_wptr = r_wptr - IW'(1);
                    end
                end else if (w_can_load) begin
                    n_occ         = r_kept;
                    n_out_valid   = 1'b1;
                    n_out_value   = '0;
                    n_out_kind    = (w_removed != '0) ? KIND_DONE : KIND_NONE;
                    n_out_removed = CntW'(w_removed);
                    n_out_last    = 1'b1;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_step      <= '0;
            r_n         <= '0;
            r_kept      <= '0;
            r_wptr      <= '0;
            r_tap       <= '0;
            r_back      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_step      <= n_step;
            r_n         <= n_n;
            r_kept      <= n_kept;
            r_wptr      <= n_wptr;
            r_tap       <= n_tap;
            r_back      <= n_back;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_val         <= n_val;
        r_out_value   <= n_out_value;
        r_out_kind    <= n_out_kind;
        r_out_removed <= n_out_removed;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_kind      = r_out_kind;
    assign o_removed   = r_out_removed;
    assign o_last      = r_out_last;

    // occupancy never goes past the ring size
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy beyond depth");

    // delete never keeps more entries than it has walked
    a_del_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL) |-> (r_kept <= r_step && r_step <= r_occ))
        else $error("delete walk out of range");

    // an accepted push back with room grows the deque by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_mode == MODE_PUSH_BACK && !w_full) |=>
            (r_occ == $past(r_occ) + CW'(1)))
        else $error("push back did not grow occupancy");

    // read elements only come out of the read walk
    a_elem_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && r_out_kind == KIND_ELEM) |-> ($past(r_state) == S_READ))
        else $error("element result outside a read");

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for the bounded deque engine
`timescale 1ns / 1ps

module tb
    import bde_pkg::*;
();

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;

    // one result transaction as the block presents it
    typedef struct packed {
        logic [ValueW-1:0] value;
        logic [KindW-1:0]  kind;
        logic [CntW-1:0]   removed;
        logic              last;
    } t_deque_result;

    // shadow copy of the deque plus the results it still owes
    class t_deque_shadow;
        logic [ValueW-1:0] words[DEPTH];
        int unsigned       head;
        int unsigned       fill;
        t_deque_result     due_results[$];
        int                errors;

        function new();
            head   = 0;
            fill   = 0;
            errors = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void owe(logic [ValueW-1:0] v, logic [KindW-1:0] k,
                          logic [CntW-1:0] r, logic l);
            t_deque_result res;
            res.value   = v;
            res.kind    = k;
            res.removed = r;
            res.last    = l;
            due_results.push_back(res);
        endfunction

        // elements from logical position first, stepping forward or backward
        function void owe_run(int unsigned first, int unsigned n, bit backward);
            int unsigned pos;
            if (n == 0) begin
                owe('0, KIND_EMPTY, '0, 1'b1);
                return;
            end
            for (int unsigned i = 0; i < n; i++) begin
                pos = backward ? first - i : first + i;
                owe(words[(head + pos) % DEPTH], KIND_ELEM, '0, i + 1 == n);
            end
        endfunction

        // word width equals the port width, so values are stored as given
        function void note_request(logic [ModeW-1:0] m, logic [ValueW-1:0] v,
                                   logic [CntW-1:0] c);
            int unsigned kept;
            int unsigned n;
            logic [ValueW-1:0] w;
            case (m)
                MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                    if (fill >= DEPTH) begin
                        owe('0, KIND_FULL, '0, 1'b1);
                    end else begin
                        if (m == MODE_PUSH_FRONT) begin
                            head = (head + DEPTH - 1) % DEPTH;
                            words[head] = v;
                        end else begin
                            words[(head + fill) % DEPTH] = v;
                        end
                        fill++;
                        owe('0, KIND_DONE, '0, 1'b1);
                    end
                end
                MODE_POP_FRONT, MODE_POP_BACK: begin
                    if (fill == 0) begin
                        owe('0, KIND_NONE, '0, 1'b1);
                    end else begin
                        if (m == MODE_POP_FRONT) head = (head + 1) % DEPTH;
                        fill--;
                        owe('0, KIND_DONE, '0, 1'b1);
                    end
                end
                MODE_CLEAR: begin
                    head = 0;
                    fill = 0;
                    owe('0, KIND_DONE, '0, 1'b1);
                end
                MODE_DELETE: begin
                    // compact survivors toward the front, order kept
                    kept = 0;
                    for (int unsigned i = 0; i < fill; i++) begin
                        w = words[(head + i) % DEPTH];
                        if (w != v) begin
                            words[(head + kept) % DEPTH] = w;
                            kept++;
                        end
                    end
                    n    = fill - kept;
                    fill = kept;
                    owe('0, n != 0 ? KIND_DONE : KIND_NONE, CntW'(n), 1'b1);
                end
                MODE_READ_ALL: owe_run(0, fill, 1'b0);
                MODE_FIRST_N: begin
                    n = c < fill ? c : fill;
                    owe_run(0, n, 1'b0);
                end
                MODE_LAST_N: begin
                    n = c < fill ? c : fill;
                    owe_run(fill != 0 ? fill - 1 : 0, n, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_deque_result got);
            t_deque_result want;
            if (due_results.size() == 0) begin
                $error("result with nothing expected: value %0d kind %0d",
                       $signed(got.value), got.kind);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.value !== want.value) begin
                $error("out_value: expected %0d, got %0d",
                       $signed(want.value), $signed(got.value));
                errors++;
            end
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.removed !== want.removed) begin
                $error("removed: expected %0d, got %0d", want.removed, got.removed);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [ModeW-1:0]  mode = MODE_CLEAR;
    logic [ValueW-1:0] value = '0;
    logic [CntW-1:0]   count = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ValueW-1:0] out_value;
    logic [KindW-1:0]  kind;
    logic [CntW-1:0]   removed;
    logic              last;

    // sender skips its random gaps while this is set
    bit                sender_steady = 1'b0;

    t_deque_shadow     shadow = new();

    bounded_deque_engine_top #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_mode      (mode),
        .i_value     (value),
        .i_count     (count),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_value (out_value),
        .o_kind      (kind),
        .o_removed   (removed),
        .o_last      (last)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // offer one request transaction; drive at the falling edge, accept at the rising edge
    task automatic send_request(input logic [ModeW-1:0] m, input logic [ValueW-1:0] v,
                                input logic [CntW-1:0] c);
        @(negedge clk);
        while (!sender_steady && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        count    <= c;
        do @(posedge clk); while (!in_ready);
        shadow.note_request(m, v, c);
    endtask

    // drop valid and wait for the block to deliver everything owed so far
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge clk);
    endtask

    // mostly a few recurring words so that delete finds matches
    function automatic logic [ValueW-1:0] pick_word();
        logic [ValueW-1:0] pool[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                       32'h7FFF_FFFF, 32'h8000_0000, 32'd42,
                                       -32'sd42, 32'h5A5A_A5A5};
        if ($urandom_range(0, 99) < 60) return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [CntW-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return CntW'($urandom_range(0, DEPTH));
        if (r < 90) return CntW'($urandom_range(0, 8));
        return CntW'($urandom_range(0, 127));
    endfunction

    // result side: random stalls, one long hold-off, one stretch with no stalls
    initial begin
        int unsigned rx_cycle;
        rx_cycle = 0;
        forever begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle >= 1500 && rx_cycle < 1800)
                out_ready <= 1'b0;
            else if (rx_cycle >= 6000 && rx_cycle < 9000)
                out_ready <= 1'b1;
            else
                out_ready <= $urandom_range(0, 99) >= 14;
        end
    end

    // every accepted result transaction goes to the scoreboard
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            shadow.check_result('{out_value, kind, removed, last});
    end

    initial begin
        int unsigned       accepted;
        int unsigned       r;
        bit                push_heavy;
        logic [ModeW-1:0]  m;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty-store cases first
        send_request(MODE_CLEAR, '0, '0);
        send_request(MODE_READ_ALL, '0, '0);
        send_request(MODE_FIRST_N, '0, 7'd5);
        send_request(MODE_LAST_N, '0, 7'd5);
        send_request(MODE_POP_FRONT, '0, '0);
        send_request(MODE_POP_BACK, '0, '0);
        send_request(MODE_DELETE, '0, '0);
        // extremes of the word, at both ends
        send_request(MODE_PUSH_FRONT, 32'h7FFF_FFFF, '0);
        send_request(MODE_PUSH_BACK, 32'h8000_0000, '0);
        send_request(MODE_PUSH_FRONT, 32'h0000_0000, '0);
        send_request(MODE_PUSH_BACK, 32'hFFFF_FFFF, '0);
        send_request(MODE_PUSH_BACK, 32'hFFFF_FFFF, '0);
        send_request(MODE_READ_ALL, '0, '0);
        // zero count, short count, count beyond occupancy and beyond the depth
        send_request(MODE_FIRST_N, '0, 7'd0);
        send_request(MODE_FIRST_N, '0, 7'd2);
        send_request(MODE_FIRST_N, '0, 7'd127);
        send_request(MODE_LAST_N, '0, 7'd1);
        send_request(MODE_LAST_N, '0, 7'd64);
        // delete with two matches, then with none
        send_request(MODE_DELETE, 32'hFFFF_FFFF, '0);
        send_request(MODE_DELETE, 32'd12345, '0);
        // unused codes are dropped without a result
        send_request(4'd9, 32'hFFFF_FFFF, 7'h7F);
        send_request(4'd15, 32'hFFFF_FFFF, 7'h7F);
        send_request(MODE_POP_FRONT, '0, '0);
        send_request(MODE_POP_BACK, '0, '0);
        send_request(MODE_READ_ALL, '0, '0);
        drain_results();

        // random traffic: phases lean toward filling up or emptying out
        accepted = 24;
        while (accepted < 500) begin
            push_heavy    = ((accepted / 60) % 2) == 0;
            sender_steady = accepted >= 300 && accepted < 400;
            r = $urandom_range(0, 99);
            if (r < 25)
                m = push_heavy ? MODE_PUSH_BACK : MODE_POP_FRONT;
            else if (r < 50)
                m = push_heavy ? MODE_PUSH_FRONT : MODE_POP_BACK;
            else if (r < 58)
                m = push_heavy ? MODE_POP_FRONT : MODE_PUSH_BACK;
            else if (r < 66)
                m = push_heavy ? MODE_POP_BACK : MODE_PUSH_FRONT;
            else if (r < 68)
                m = MODE_CLEAR;
            else if (r < 76)
                m = MODE_DELETE;
            else if (r < 82)
                m = MODE_READ_ALL;
            else if (r < 90)
                m = MODE_FIRST_N;
            else if (r < 98)
                m = MODE_LAST_N;
            else
                m = ModeW'($urandom_range(9, 15));
            send_request(m, pick_word(), pick_count());
            if (m <= MODE_LAST_N) accepted++;
            // one full pause with the result side caught up
            if (accepted == 250) drain_results();
        end

        drain_results();
        sender_steady = 1'b0;
        repeat (4 * DEPTH) @(posedge clk);

        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/bde_pkg.sv
hw/rtl/bde_cell.sv
hw/rtl/bounded_deque_engine_top.sv
tb/tb.sv
